[rtl/host_liveness_wake_guard_core_assert.svh]
// Assertion macros for the host liveness wake guard.
// Included by the modules that check their own logic; expects a clk and an arst_n in scope.
`ifndef HOST_LIVENESS_WAKE_GUARD_CORE_ASSERT_SVH
`define HOST_LIVENESS_WAKE_GUARD_CORE_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define HLWG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define HLWG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/hlwg_pkg.sv]
// Shared types and constants of the host liveness wake guard.
// Used by hlwg_cfg and host_liveness_wake_guard_core; depends on nothing.
package hlwg_pkg;

	localparam int TIME_BITS_DEF = 48;
	localparam int FIELD_TIME_W  = 48;
	localparam int CMD_W         = 3;
	localparam int STATE_W       = 3;
	localparam int ATT_W         = 16;
	localparam int WCNT_W        = 32;
	localparam int MIN_W         = 10;
	localparam int MAXATT_W      = 8;
	localparam int SNZ_W         = 16;
	localparam int SPAN_W        = 26;
	localparam int ADD_W         = 32;
	localparam int APB_ADDR_W    = 4;
	localparam int APB_DATA_W    = 32;
	localparam int IN_DATA_W     = 72;
	localparam int OUT_DATA_W    = 104;
	localparam int REG_IDX_W     = 2;

	localparam logic [15:0] MS_PER_MIN = 16'd60000;

	localparam logic [MIN_W-1:0]    GRACE_RESET  = 10'd5;
	localparam logic [MIN_W-1:0]    RETRY_RESET  = 10'd5;
	localparam logic [MAXATT_W-1:0] MAXATT_RESET = 8'd3;

	// Register indexes, taken from paddr[3:2].
	localparam logic [REG_IDX_W-1:0] REG_GRACE  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RETRY  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MAXATT = 2'd2;

	localparam logic [CMD_W-1:0] CMD_CHECK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SNOOZE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MANUAL = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_APPLY  = 3'd4;

	localparam logic [STATE_W-1:0] ST_DISABLED = 3'd0;
	localparam logic [STATE_W-1:0] ST_WATCHING = 3'd1;
	localparam logic [STATE_W-1:0] ST_MISSING  = 3'd2;
	localparam logic [STATE_W-1:0] ST_WAKING   = 3'd3;
	localparam logic [STATE_W-1:0] ST_GAVE_UP  = 3'd4;
	localparam logic [STATE_W-1:0] ST_SNOOZING = 3'd5;

	// Settings as the decision logic needs them: spans already in milliseconds.
	typedef struct packed {
		logic [SPAN_W-1:0]   grace_span;
		logic [SPAN_W-1:0]   retry_span;
		logic [MAXATT_W-1:0] max_att;
	} cfg_t;

endpackage

[rtl/host_liveness_wake_guard_core.sv]
// Host liveness wake guard: takes one event per cycle and returns one status transfer per event.
// An event is held in an input register, decided against the guard state by one level of
// compare logic, and its status lands in a result register that also holds the new state.
// One event is accepted every cycle while the result side takes transfers, and the input side
// stalls only when both registers are full. Settings are written through the APB-style port;
// the user must write them only while no event is in flight, which the block does not enforce.
// Grace and retry spans are converted to milliseconds at write time.
module host_liveness_wake_guard_core #(
	parameter int TIME_BITS = hlwg_pkg::TIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// tuser: command[2:0]
	input  logic [hlwg_pkg::CMD_W-1:0]       s_axis_tuser,
	// tdata: now_ms[47:0], link_up[48], ping_ok[49], snooze_minutes[65:50], enable_flag[66]
	input  logic [hlwg_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// tdata: guard_state[2:0], wake_request[3], series_attempts[19:4], wake_total[51:20],
	// host_up[52], seen_time_ms[100:53], seen_ever[101]
	output logic [hlwg_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [hlwg_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [hlwg_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [hlwg_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready
);
	import hlwg_pkg::*;

	// Time is kept modulo 2^TIME_BITS, never wider than the field.
	localparam int TW = (TIME_BITS < FIELD_TIME_W) ? TIME_BITS : FIELD_TIME_W;

	cfg_t cfg;

	hlwg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register.
	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [TW-1:0]     now_s1;
	logic              link_s1;
	logic              ping_s1;
	logic [SNZ_W-1:0]  snz_s1;
	logic              en_s1;

	// Guard state.
	logic               guard_on_q;
	logic [STATE_W-1:0] mode_q;
	logic [TW-1:0]      silent_since_q;
	logic               silent_valid_q;
	logic [TW-1:0]      last_wake_q;
	logic               wake_valid_q;
	logic [TW-1:0]      snooze_end_q;
	logic [ATT_W-1:0]   attempt_q;
	logic [WCNT_W-1:0]  wake_cnt_q;
	logic               alive_q;
	logic [TW-1:0]      seen_stamp_q;
	logic               seen_valid_q;

	logic               n_guard_on;
	logic [STATE_W-1:0] n_mode;
	logic [TW-1:0]      n_silent_since;
	logic               n_silent_valid;
	logic [TW-1:0]      n_last_wake;
	logic               n_wake_valid;
	logic [TW-1:0]      n_snooze_end;
	logic [ATT_W-1:0]   n_attempt;
	logic [WCNT_W-1:0]  n_wake_cnt;
	logic               n_alive;
	logic [TW-1:0]      n_seen_stamp;
	logic               n_seen_valid;
	logic               pulse;

	logic [TW-1:0]      start_g;
	logic               in_grace;
	logic               in_retry;
	logic               exhausted;
	logic               snooze_on;
	logic [ADD_W-1:0]   snz_add;
	logic [TW:0]        snz_sum;

	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic                  adv;
	logic                  take;

	assign adv           = !m_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;
	assign take          = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= s_axis_tuser;
			now_s1  <= s_axis_tdata[TW-1:0];
			link_s1 <= s_axis_tdata[48];
			ping_s1 <= s_axis_tdata[49];
			snz_s1  <= s_axis_tdata[65:50];
			en_s1   <= s_axis_tdata[66];
		end
	end

	// A silent host with no missing mark starts it at this event, so its grace starts now.
	assign start_g   = silent_valid_q ? silent_since_q : now_s1;
	assign in_grace  = (now_s1 < start_g) || ((now_s1 - start_g) < TW'(cfg.grace_span));
	assign in_retry  = wake_valid_q &&
		((now_s1 < last_wake_q) || ((now_s1 - last_wake_q) < TW'(cfg.retry_span)));
	assign exhausted = (cfg.max_att != '0) && (attempt_q >= ATT_W'(cfg.max_att));
	assign snooze_on = snooze_end_q > now_s1;
	assign snz_add   = ADD_W'(snz_s1) * ADD_W'(MS_PER_MIN);
	// A carry out of the time width means the snooze end saturates at the largest time.
	assign snz_sum   = {1'b0, now_s1} + (TW+1)'(snz_add);

	always_comb begin
		n_guard_on     = guard_on_q;
		n_mode         = mode_q;
		n_silent_since = silent_since_q;
		n_silent_valid = silent_valid_q;
		n_last_wake    = last_wake_q;
		n_wake_valid   = wake_valid_q;
		n_snooze_end   = snooze_end_q;
		n_attempt      = attempt_q;
		n_wake_cnt     = wake_cnt_q;
		n_alive        = alive_q;
		n_seen_stamp   = seen_stamp_q;
		n_seen_valid   = seen_valid_q;
		pulse          = 1'b0;
		case (cmd_s1)
			CMD_CHECK: begin
				if (!guard_on_q) begin
					n_mode         = ST_DISABLED;
					n_silent_since = '0;
					n_silent_valid = 1'b0;
				end else if (link_s1) begin
					n_alive = ping_s1;
					if (ping_s1) begin
						n_seen_stamp   = now_s1;
						n_seen_valid   = 1'b1;
						n_attempt      = '0;
						n_silent_since = '0;
						n_silent_valid = 1'b0;
						n_mode         = ST_WATCHING;
					end else if (snooze_on) begin
						n_mode = ST_SNOOZING;
					end else begin
						n_silent_since = start_g;
						n_silent_valid = 1'b1;
						if (exhausted) begin
							n_mode = ST_GAVE_UP;
						end else if (in_grace) begin
							n_mode = ST_MISSING;
						end else if (in_retry) begin
							n_mode = ST_WAKING;
						end else begin
							n_attempt    = attempt_q + 1'b1;
							n_wake_cnt   = wake_cnt_q + 1'b1;
							n_last_wake  = now_s1;
							n_wake_valid = 1'b1;
							n_mode       = ST_WAKING;
							pulse        = 1'b1;
						end
					end
				end
			end
			CMD_SNOOZE: begin
				if (snz_s1 == '0) begin
					n_snooze_end = '0;
				end else begin
					n_snooze_end = snz_sum[TW] ? '1 : snz_sum[TW-1:0];
					n_attempt    = '0;
				end
			end
			CMD_MANUAL: begin
				n_wake_cnt = wake_cnt_q + 1'b1;
				pulse      = 1'b1;
			end
			CMD_TOGGLE: begin
				n_guard_on = !guard_on_q;
				n_attempt  = '0;
				n_mode     = guard_on_q ? ST_DISABLED : ST_WATCHING;
			end
			CMD_APPLY: begin
				n_guard_on = en_s1;
				n_attempt  = '0;
				n_mode     = en_s1 ? ST_WATCHING : ST_DISABLED;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			guard_on_q     <= 1'b0;
			mode_q         <= ST_DISABLED;
			silent_since_q <= '0;
			silent_valid_q <= 1'b0;
			last_wake_q    <= '0;
			wake_valid_q   <= 1'b0;
			snooze_end_q   <= '0;
			attempt_q      <= '0;
			wake_cnt_q     <= '0;
			alive_q        <= 1'b0;
			seen_stamp_q   <= '0;
			seen_valid_q   <= 1'b0;
		end else if (take) begin
			guard_on_q     <= n_guard_on;
			mode_q         <= n_mode;
			silent_since_q <= n_silent_since;
			silent_valid_q <= n_silent_valid;
			last_wake_q    <= n_last_wake;
			wake_valid_q   <= n_wake_valid;
			snooze_end_q   <= n_snooze_end;
			attempt_q      <= n_attempt;
			wake_cnt_q     <= n_wake_cnt;
			alive_q        <= n_alive;
			seen_stamp_q   <= n_seen_stamp;
			seen_valid_q   <= n_seen_valid;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			m_data_q <= {2'b00,
				n_seen_valid,
				n_seen_valid ? FIELD_TIME_W'(n_seen_stamp) : {FIELD_TIME_W{1'b0}},
				n_alive,
				n_wake_cnt,
				n_attempt,
				pulse,
				n_mode};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	`include "host_liveness_wake_guard_core_assert.svh"

	`HLWG_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |=> !m_axis_tvalid, "result valid after reset")
	`HLWG_ASSERT(a_mode_matches_enable, (mode_q == ST_DISABLED) == !guard_on_q, "mode and enable disagree")
	`HLWG_ASSERT(a_stall_blocks_input, (valid_s1 && !adv) |-> !s_axis_tready, "input taken while full")
	`HLWG_ASSERT(a_pulse_counts, (take && pulse) |=> (wake_cnt_q == $past(wake_cnt_q) + 1'b1), "wake pulse not counted")
	`HLWG_ASSERT(a_unseen_time_zero, (m_axis_tvalid && !m_axis_tdata[101]) |-> (m_axis_tdata[100:53] == '0), "seen time without seen flag")

endmodule

[rtl/hlwg_cfg.sv]
// Configuration registers of the host liveness wake guard behind an APB-style port.
// Depends on hlwg_pkg; keeps the spans converted to milliseconds next to the raw minutes.
module hlwg_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [hlwg_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [hlwg_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [hlwg_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	output hlwg_pkg::cfg_t                   cfg
);
	import hlwg_pkg::*;

	logic [MIN_W-1:0]     grace_min_q;
	logic [MIN_W-1:0]     retry_min_q;
	logic [MAXATT_W-1:0]  max_att_q;
	logic [SPAN_W-1:0]    grace_span_q;
	logic [SPAN_W-1:0]    retry_span_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr;
	logic [SPAN_W-1:0]    wr_ms;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr     = psel && penable && pwrite && pready;
	assign wr_ms  = SPAN_W'(pwdata[MIN_W-1:0]) * SPAN_W'(MS_PER_MIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grace_min_q  <= GRACE_RESET;
			retry_min_q  <= RETRY_RESET;
			max_att_q    <= MAXATT_RESET;
			grace_span_q <= SPAN_W'(GRACE_RESET) * SPAN_W'(MS_PER_MIN);
			retry_span_q <= SPAN_W'(RETRY_RESET) * SPAN_W'(MS_PER_MIN);
		end else if (wr) begin
			case (idx)
				REG_GRACE: begin
					grace_min_q  <= pwdata[MIN_W-1:0];
					grace_span_q <= wr_ms;
				end
				REG_RETRY: begin
					retry_min_q  <= pwdata[MIN_W-1:0];
					retry_span_q <= wr_ms;
				end
				REG_MAXATT: begin
					max_att_q <= pwdata[MAXATT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_GRACE:  prdata = APB_DATA_W'(grace_min_q);
			REG_RETRY:  prdata = APB_DATA_W'(retry_min_q);
			REG_MAXATT: prdata = APB_DATA_W'(max_att_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.grace_span = grace_span_q;
	assign cfg.retry_span = retry_span_q;
	assign cfg.max_att    = max_att_q;

endmodule
